/* hw/rtl/nnfs_pkg.sv */
// Shared types, widths and register indexes for the nearest-neighbor fit scaler.
// Used by every module of the block; depends on nothing.
package nnfs_pkg;

    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int PIX_W     = 32;
    localparam int PROD_W    = 2 * DIM_W;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_DIM   = 4096;
    localparam int DIV_STEPS = DIM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef logic [DIM_W-1:0]  dim_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [PROD_W-1:0] prod_t;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIDE   = 2'd2;

    localparam dim_t SRC_WIDTH_RST  = 13'd1024;
    localparam dim_t SRC_HEIGHT_RST = 13'd1024;
    localparam dim_t MAX_SIDE_RST   = 13'd256;

    typedef struct packed {
        logic pass;
        dim_t m;
        dim_t s;
        pos_t w_m1;
        pos_t h_m1;
        dim_t nw;
        dim_t nh;
        dim_t nw_m1;
        dim_t nh_m1;
    } geom_t;

    // Zero is taken as one, and anything above the largest dimension as that dimension.
    function automatic dim_t eff_dim(input dim_t v);
        dim_t r;
        if (v == '0) begin
            r = dim_t'(1);
        end else if (v > dim_t'(MAX_DIM)) begin
            r = dim_t'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/nnfs_div.sv */
// Restoring divider, one quotient bit per cycle, for the output frame size.
// Depends on nnfs_pkg.
module nnfs_div
    import nnfs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  prod_t dividend,
    input  dim_t  divisor,
    output dim_t  quotient,
    output logic  busy
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    dim_t                 rem_reg;
    dim_t                 quo_reg;
    logic [DIM_W:0]       trial;
    logic                 ge;

    // The quotient is known to fit, so the upper half of the dividend is below the divisor.
    always_comb begin
        trial = {rem_reg, quo_reg[DIM_W-1]};
        ge    = trial >= {1'b0, divisor};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[PROD_W-1:DIM_W];
            quo_reg <= dividend[DIM_W-1:0];
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
            quo_reg <= {quo_reg[DIM_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign busy     = (cnt_reg != '0);

endmodule

/* hw/rtl/nnfs_setup.sv */
// Frame geometry sequencer: clamps the registers, picks pass-through or downscale
// and divides out the output size. Depends on nnfs_pkg and nnfs_div.
module nnfs_setup
    import nnfs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  dim_t  src_width,
    input  dim_t  src_height,
    input  dim_t  max_side,
    output geom_t geom,
    output logic  busy
);

    typedef enum logic [2:0] {
        SU_IDLE,
        SU_EFF,
        SU_MUL,
        SU_DIV_START,
        SU_DIV_WAIT
    } su_state_t;

    su_state_t state_reg;
    dim_t      w_reg;
    dim_t      h_reg;
    dim_t      s_reg;
    dim_t      m_reg;
    logic      pass_reg;
    prod_t     prod_w_reg;
    prod_t     prod_h_reg;
    geom_t     geom_reg;

    dim_t  w_eff;
    dim_t  h_eff;
    dim_t  s_eff;
    dim_t  qw;
    dim_t  qh;
    dim_t  nw;
    dim_t  nh;
    logic  div_start;
    logic  div_w_busy;
    logic  div_h_busy;

    always_comb begin
        w_eff     = eff_dim(src_width);
        h_eff     = eff_dim(src_height);
        s_eff     = eff_dim(max_side);
        nw        = (qw == '0) ? dim_t'(1) : qw;
        nh        = (qh == '0) ? dim_t'(1) : qh;
        div_start = (state_reg == SU_DIV_START);
    end

    nnfs_div u_div_w (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_w_reg),
        .divisor  (m_reg),
        .quotient (qw),
        .busy     (div_w_busy)
    );

    nnfs_div u_div_h (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_h_reg),
        .divisor  (m_reg),
        .quotient (qh),
        .busy     (div_h_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_EFF;
        end else if (start) begin
            state_reg <= SU_EFF;
        end else begin
            unique case (state_reg)
                SU_IDLE: begin
                    state_reg <= SU_IDLE;
                end
                SU_EFF: begin
                    w_reg     <= w_eff;
                    h_reg     <= h_eff;
                    s_reg     <= s_eff;
                    m_reg     <= (w_eff > h_eff) ? w_eff : h_eff;
                    pass_reg  <= (w_eff <= s_eff) && (h_eff <= s_eff);
                    state_reg <= SU_MUL;
                end
                SU_MUL: begin
                    prod_w_reg <= PROD_W'(w_reg) * PROD_W'(s_reg);
                    prod_h_reg <= PROD_W'(h_reg) * PROD_W'(s_reg);
                    state_reg  <= SU_DIV_START;
                end
                SU_DIV_START: begin
                    state_reg <= SU_DIV_WAIT;
                end
                SU_DIV_WAIT: begin
                    if (!div_w_busy && !div_h_busy) begin
                        geom_reg.pass  <= pass_reg;
                        geom_reg.m     <= m_reg;
                        geom_reg.s     <= s_reg;
                        geom_reg.w_m1  <= POS_W'(w_reg - 1'b1);
                        geom_reg.h_m1  <= POS_W'(h_reg - 1'b1);
                        geom_reg.nw    <= nw;
                        geom_reg.nh    <= nh;
                        geom_reg.nw_m1 <= nw - 1'b1;
                        geom_reg.nh_m1 <= nh - 1'b1;
                        state_reg      <= SU_IDLE;
                    end
                end
                default: begin
                    state_reg <= SU_IDLE;
                end
            endcase
        end
    end

    assign geom = geom_reg;
    assign busy = (state_reg != SU_IDLE);

endmodule

/* hw/rtl/nnfs_core.sv */
// Pixel datapath: input register, source and output position counters with
// column and row residues, and the result register. Depends on nnfs_pkg.
module nnfs_core
    import nnfs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  restart,
    input  logic  in_hold,
    input  geom_t geom,
    input  logic  s_valid,
    output logic  s_ready,
    input  pix_t  s_pixel_in,
    output logic  m_valid,
    input  logic  m_ready,
    output pix_t  m_pixel_out,
    output pos_t  m_out_col,
    output pos_t  m_out_row,
    output logic  m_frame_last
);

    logic in_vld_reg;
    pix_t in_pix_reg;

    pos_t src_col_reg;
    pos_t src_row_reg;
    pos_t dst_col_reg;
    pos_t dst_row_reg;
    pos_t col_res_reg;
    pos_t row_res_reg;
    logic row_kept_reg;

    pos_t src_col_next;
    pos_t src_row_next;
    pos_t dst_col_next;
    pos_t dst_row_next;
    pos_t col_res_next;
    pos_t row_res_next;
    logic row_kept_next;

    logic m_valid_reg;
    pix_t pix_out_reg;
    pos_t out_col_reg;
    pos_t out_row_reg;
    logic last_reg;

    logic proceed;
    logic row_end;
    logic frame_end;
    logic col_avail;
    logic col_keep;
    logic row_avail;
    logic emit;
    pos_t emit_col;
    pos_t emit_row;
    logic emit_last;
    pos_t dst_row_upd;
    pos_t row_res_upd;

    assign proceed = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_hold && (!in_vld_reg || proceed);

    always_comb begin
        row_end   = (src_col_reg >= geom.w_m1);
        frame_end = row_end && (src_row_reg >= geom.h_m1);
        col_avail = (DIM_W'(dst_col_reg) < geom.nw);
        col_keep  = col_avail && (DIM_W'(col_res_reg) < geom.s);
        row_avail = (DIM_W'(dst_row_reg) < geom.nh);

        if (geom.pass) begin
            emit      = 1'b1;
            emit_col  = src_col_reg;
            emit_row  = src_row_reg;
            emit_last = frame_end;
        end else begin
            emit      = row_kept_reg && col_keep;
            emit_col  = dst_col_reg;
            emit_row  = dst_row_reg;
            emit_last = (DIM_W'(dst_col_reg) == geom.nw_m1)
                     && (DIM_W'(dst_row_reg) == geom.nh_m1);
        end

        dst_row_upd = dst_row_reg;
        row_res_upd = row_res_reg;
        if (row_avail) begin
            if (row_kept_reg) begin
                dst_row_upd = dst_row_reg + 1'b1;
                row_res_upd = POS_W'(DIM_W'(row_res_reg) + geom.m - geom.s);
            end else begin
                row_res_upd = POS_W'(DIM_W'(row_res_reg) - geom.s);
            end
        end

        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        dst_col_next  = dst_col_reg;
        dst_row_next  = dst_row_reg;
        col_res_next  = col_res_reg;
        row_res_next  = row_res_reg;
        row_kept_next = row_kept_reg;

        if (proceed) begin
            if (!geom.pass) begin
                if (col_avail) begin
                    if (col_keep) begin
                        dst_col_next = dst_col_reg + 1'b1;
                        col_res_next = POS_W'(DIM_W'(col_res_reg) + geom.m - geom.s);
                    end else begin
                        col_res_next = POS_W'(DIM_W'(col_res_reg) - geom.s);
                    end
                end
                if (row_end && !frame_end) begin
                    dst_row_next  = dst_row_upd;
                    row_res_next  = row_res_upd;
                    row_kept_next = (DIM_W'(dst_row_upd) < geom.nh)
                                 && (DIM_W'(row_res_upd) < geom.s);
                end
            end

            if (frame_end) begin
                src_col_next  = '0;
                src_row_next  = '0;
                dst_col_next  = '0;
                dst_row_next  = '0;
                col_res_next  = '0;
                row_res_next  = '0;
                row_kept_next = 1'b1;
            end else if (row_end) begin
                src_col_next = '0;
                src_row_next = src_row_reg + 1'b1;
                dst_col_next = '0;
                col_res_next = '0;
            end else begin
                src_col_next = src_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (proceed) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_pix_reg <= s_pixel_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            dst_col_reg  <= '0;
            dst_row_reg  <= '0;
            col_res_reg  <= '0;
            row_res_reg  <= '0;
            row_kept_reg <= 1'b1;
        end else begin
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            dst_col_reg  <= dst_col_next;
            dst_row_reg  <= dst_row_next;
            col_res_reg  <= col_res_next;
            row_res_reg  <= row_res_next;
            row_kept_reg <= row_kept_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proceed) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && emit) begin
            pix_out_reg <= in_pix_reg;
            out_col_reg <= emit_col;
            out_row_reg <= emit_row;
            last_reg    <= emit_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = pix_out_reg;
    assign m_out_col    = out_col_reg;
    assign m_out_row    = out_row_reg;
    assign m_frame_last = last_reg;

endmodule

/* hw/rtl/nearest_neighbor_fit_scaler.sv */
// Nearest-neighbor fit scaler: one source RGBA word per clock in, unless the input
// is held off or the output stalls, and at most one output word out, with its
// output column, row and end-of-frame flag. A source word passes the input register
// and then the result register around the position and residue update. After reset,
// and from a register write on, the input is held off while the output size is
// divided out, one quotient bit per cycle. Depends on nnfs_pkg, nnfs_setup and
// nnfs_core.
module nearest_neighbor_fit_scaler
    import nnfs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_pixel_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_pixel_out,
    output logic [POS_W-1:0]     m_out_col,
    output logic [POS_W-1:0]     m_out_row,
    output logic                 m_frame_last
);

    dim_t  src_width_reg;
    dim_t  src_height_reg;
    dim_t  max_side_reg;
    logic  cfg_wr;
    logic  setup_busy;
    logic  in_hold;
    geom_t geom;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready
                    && (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT
                        || cfg_index == REG_MAX_SIDE);
    assign in_hold   = setup_busy || cfg_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= SRC_WIDTH_RST;
            src_height_reg <= SRC_HEIGHT_RST;
            max_side_reg   <= MAX_SIDE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                REG_MAX_SIDE:   max_side_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    nnfs_setup u_setup (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cfg_wr),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .max_side   (max_side_reg),
        .geom       (geom),
        .busy       (setup_busy)
    );

    nnfs_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .restart      (cfg_wr),
        .in_hold      (in_hold),
        .geom         (geom),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_out_col    (m_out_col),
        .m_out_row    (m_out_row),
        .m_frame_last (m_frame_last)
    );

    // A register write must hold off the input until the new size is known.
    a_cfg_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_ready)
        else $error("input taken right after a register write");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !geom.pass) |-> (DIM_W'(m_out_col) < geom.nw))
        else $error("output column beyond output width");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !geom.pass) |-> (DIM_W'(m_out_row) < geom.nh))
        else $error("output row beyond output height");

endmodule
